>>> src/bclg_pkg.sv
// Shared package of the breathing color LED generator: field widths, reset values,
// register indexes, sequencer and command types, and the elaboration-time sigmoid
// table builder. Depends on nothing.
package bclg_pkg;

  localparam int STEPS_DEFAULT         = 266;
  localparam int FRACTION_BITS_DEFAULT = 16;

  // Field widths
  localparam int LEVEL_W     = 16;
  localparam int CHAN_W      = 13;
  localparam int HUE_W       = 10;
  localparam int DUTY_W      = 13;
  localparam int BRIGHT_W    = 8;
  localparam int SCALE_W     = LEVEL_W + DUTY_W;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 72;

  // Register reset values
  localparam logic             OUTPUT_MODE_RESET  = 1'b0;
  localparam logic [DUTY_W-1:0]   PWM_DUTY_RESET  = 13'd819;
  localparam logic [BRIGHT_W-1:0] STRIP_BRIGHT_RESET = 8'd25;

  localparam logic MODE_PWM   = 1'b0;
  localparam logic MODE_STRIP = 1'b1;

  // Sigmoid table construction
  localparam int          STEEPNESS     = 8;
  localparam int          EXP_TERMS     = 24;
  localparam int          EXP_ONE_SHIFT = 30;
  localparam logic [63:0] EXP_ONE       = 64'd1 << EXP_ONE_SHIFT;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_OUTPUT_MODE          = 2'd0,
    CFG_PWM_MAX_DUTY         = 2'd1,
    CFG_STRIP_MAX_BRIGHTNESS = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DIVIDE,
    ST_MUL_LEVEL,
    ST_MUL_RISE,
    ST_MUL_FALL,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    MUL_SEL_LEVEL,
    MUL_SEL_RISE,
    MUL_SEL_FALL
  } mul_sel_t;

  typedef enum logic [1:0] {
    W_ZERO,
    W_RISE,
    W_FALL,
    W_FULL
  } weight_t;

  typedef struct packed {
    logic     step;
    logic     lookup;
    logic     div_step;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     load_out;
  } bclg_cmd_t;

  // Restoring division, used only while building constant tables.
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^-(r/steps) in Q2.30, truncated Taylor series
  function automatic logic [63:0] exp_neg(input logic [63:0] r, input logic [63:0] steps);
    logic [63:0] term;
    logic [63:0] sum;
    term = EXP_ONE;
    sum  = EXP_ONE;
    for (int n = 1; n <= EXP_TERMS; n++) begin
      term = div_u64(term * r, 64'(n) * steps);
      if ((n & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Sigmoid level for breath index k, unsigned Q0.16, rounded to nearest
  function automatic logic [LEVEL_W-1:0] level_entry(input logic [63:0] k,
                                                     input logic [63:0] steps,
                                                     input logic [63:0] e1);
    logic [63:0] up;
    logic [63:0] down;
    logic [63:0] mag;
    logic [63:0] whole;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] s;
    logic        pos;
    up    = 64'(2 * STEEPNESS) * k;
    down  = 64'(STEEPNESS) * steps;
    pos   = (up >= down);
    mag   = pos ? (up - down) : (down - up);
    whole = div_u64(mag, steps);
    e     = exp_neg(mag - whole * steps, steps);
    if (whole > 64'(2 * STEEPNESS)) begin
      whole = 64'(2 * STEEPNESS);
    end
    for (int i = 0; i < 2 * STEEPNESS; i++) begin
      if (64'(i) < whole) begin
        e = (e * e1) >> EXP_ONE_SHIFT;
      end
    end
    d = EXP_ONE + e;
    if (pos) begin
      s = div_u64((64'd1 << (EXP_ONE_SHIFT + LEVEL_W)) + (d >> 1), d);
    end else begin
      s = div_u64((e << LEVEL_W) + (d >> 1), d);
    end
    return s[LEVEL_W-1:0];
  endfunction

endpackage

>>> src/bclg_level_rom.sv
// Sigmoid brightness table of the breathing color LED generator, in banks of
// 256 constant words with registered read. Depends on bclg_pkg.
module bclg_level_rom
  import bclg_pkg::*;
#(
  parameter int STEPS = STEPS_DEFAULT
) (
  input  logic                       clk,
  input  logic [$clog2(STEPS+1)-1:0] addr,
  output logic [LEVEL_W-1:0]         level
);

  localparam int BANK_DEPTH = 256;
  localparam int BANK_AW    = 8;
  localparam int BANKS      = (STEPS + BANK_DEPTH) / BANK_DEPTH;
  localparam int BANK_W     = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int EXT_W      = BANK_W + BANK_AW;
  localparam logic [63:0] E1 = exp_neg(64'(STEPS), 64'(STEPS));

  logic [EXT_W-1:0]   addr_ext;
  logic [LEVEL_W-1:0] rom_word [BANKS][BANK_DEPTH];
  logic [LEVEL_W-1:0] bank_q   [BANKS];
  logic [BANK_W-1:0]  bank_sel;

  assign addr_ext = EXT_W'(addr);

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    for (genvar i = 0; i < BANK_DEPTH; i++) begin : g_entry
      localparam int K = b * BANK_DEPTH + i;
      localparam logic [LEVEL_W-1:0] WORD =
        (K <= STEPS) ? level_entry(64'(K), 64'(STEPS), E1) : '0;
      assign rom_word[b][i] = WORD;
    end

    always_ff @(posedge clk) begin
      bank_q[b] <= rom_word[b][addr_ext[BANK_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    bank_sel <= addr_ext[EXT_W-1:BANK_AW];
  end

  assign level = bank_q[bank_sel];

endmodule

>>> src/bclg_datapath.sv
// Datapath of the breathing color LED generator: configuration registers, animation
// state, sector split, reciprocal fraction multiplier, shared multiplier, output register.
// Depends on bclg_pkg and bclg_level_rom.
module bclg_datapath
  import bclg_pkg::*;
#(
  parameter int STEPS         = STEPS_DEFAULT,
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick,
  input  bclg_cmd_t              cmd,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output logic [CHAN_W-1:0]      red_level,
  output logic [CHAN_W-1:0]      green_level,
  output logic [CHAN_W-1:0]      blue_level,
  output logic [HUE_W-1:0]       hue_position,
  output logic [LEVEL_W-1:0]     breath_level
);

  localparam int FB     = FRACTION_BITS;
  localparam int BI_W   = $clog2(STEPS + 1);
  localparam int SIX_W  = HUE_W + 3;
  localparam int REM_W  = $clog2(STEPS);
  localparam int A_W    = (FB + 1 > LEVEL_W) ? FB + 1 : LEVEL_W;
  localparam int B_W    = SCALE_W;
  localparam int PROD_W = A_W + B_W;
  localparam logic [FB:0] FULL_W = (FB + 1)'(1) << FB;

  // floor(rem*2^FB/STEPS) = (rem*RECIP) >> RECIP_SHIFT, exact for every rem < STEPS
  localparam int          RECIP_SHIFT = 2 * REM_W;
  localparam int          RECIP_W     = FB + REM_W + 1;
  localparam int          FPROD_W     = REM_W + RECIP_W;
  localparam logic [63:0] RECIP_WIDE  = (64'd1 << (FB + RECIP_SHIFT)) / 64'(STEPS) + 64'd1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];

  logic                output_mode;
  logic [DUTY_W-1:0]   pwm_max_duty;
  logic [BRIGHT_W-1:0] strip_max_brightness;

  logic [HUE_W-1:0]    hue_index;
  logic [BI_W-1:0]     breath_index;
  logic                breath_rising;

  logic [2:0]          sector;
  logic [REM_W-1:0]    div_rem;
  logic [FB-1:0]       frac;
  logic [LEVEL_W-1:0]  level_q;
  logic [B_W-1:0]      scale;
  logic [PROD_W-1:0]   rise_prod;
  logic [PROD_W-1:0]   fall_prod;

  logic [HUE_W:0]      hue_inc;
  logic [BI_W:0]       breath_inc;
  logic [SIX_W-1:0]    six;
  logic [2:0]          sec_c;
  logic [SIX_W-1:0]    rem_c;
  logic [FPROD_W-1:0]  frac_prod;
  logic [LEVEL_W-1:0]  rom_level;
  logic                strip;
  logic [FB:0]         fall_w;
  logic [FB+7:0]       rise255;
  logic [FB+8:0]       fall255;
  logic [BRIGHT_W-1:0] ch_rise;
  logic [BRIGHT_W-1:0] ch_fall;
  logic [BRIGHT_W-1:0] strip_b;
  logic [A_W-1:0]      mul_a;
  logic [B_W-1:0]      mul_b;
  logic [PROD_W-1:0]   product;
  logic [CHAN_W-1:0]   full_val;
  logic [CHAN_W-1:0]   rise_val;
  logic [CHAN_W-1:0]   fall_val;
  weight_t             w_red;
  weight_t             w_green;
  weight_t             w_blue;

  // floor(x/255) for x up to 255*255
  function automatic logic [BRIGHT_W-1:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [CHAN_W-1:0] pick(input weight_t w, input logic [CHAN_W-1:0] rv,
                                            input logic [CHAN_W-1:0] fv,
                                            input logic [CHAN_W-1:0] uv);
    logic [CHAN_W-1:0] v;
    unique case (w)
      W_RISE:  v = rv;
      W_FALL:  v = fv;
      W_FULL:  v = uv;
      default: v = '0;
    endcase
    return v;
  endfunction

  bclg_level_rom #(
    .STEPS (STEPS)
  ) u_rom (
    .clk   (clk),
    .addr  (breath_index),
    .level (rom_level)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      output_mode          <= OUTPUT_MODE_RESET;
      pwm_max_duty         <= PWM_DUTY_RESET;
      strip_max_brightness <= STRIP_BRIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OUTPUT_MODE:          output_mode          <= cfg_wdata[0];
        CFG_PWM_MAX_DUTY:         pwm_max_duty         <= cfg_wdata[DUTY_W-1:0];
        CFG_STRIP_MAX_BRIGHTNESS: strip_max_brightness <= cfg_wdata[BRIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Animation state
  assign hue_inc    = {1'b0, hue_index} + (HUE_W + 1)'(1);
  assign breath_inc = {1'b0, breath_index} + (BI_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_index     <= '0;
      breath_index  <= '0;
      breath_rising <= 1'b1;
    end else if (cmd.step && tick) begin
      hue_index <= (hue_inc >= (HUE_W + 1)'(STEPS)) ? '0 : hue_inc[HUE_W-1:0];
      if (breath_rising) begin
        if (breath_inc >= (BI_W + 1)'(STEPS)) begin
          breath_index  <= BI_W'(STEPS);
          breath_rising <= 1'b0;
        end else begin
          breath_index <= breath_inc[BI_W-1:0];
        end
      end else if (breath_index <= BI_W'(1)) begin
        breath_index  <= '0;
        breath_rising <= 1'b1;
      end else begin
        breath_index <= breath_index - BI_W'(1);
      end
    end
  end

  // Sector and remainder of 6*hue by STEPS
  assign six = SIX_W'({hue_index, 2'b00}) + SIX_W'({hue_index, 1'b0});

  always_comb begin
    sec_c = 3'd0;
    rem_c = six;
    for (int k = 1; k < 6; k++) begin
      if (six >= SIX_W'(k * STEPS)) begin
        sec_c = 3'(k);
        rem_c = six - SIX_W'(k * STEPS);
      end
    end
  end

  // Fraction of the sector by reciprocal multiplication
  assign frac_prod = FPROD_W'(div_rem) * FPROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      sector  <= sec_c;
      div_rem <= REM_W'(rem_c);
    end else if (cmd.div_step) begin
      frac <= frac_prod[RECIP_SHIFT +: FB];
    end
  end

  // Channel weights
  assign strip   = (output_mode == MODE_STRIP);
  assign fall_w  = FULL_W - {1'b0, frac};
  assign rise255 = {frac, 8'b0} - (FB + 8)'(frac);
  assign fall255 = {fall_w, 8'b0} - (FB + 9)'(fall_w);
  assign ch_rise = rise255[FB+7:FB];
  assign ch_fall = fall255[FB+7:FB];
  assign strip_b = scale[LEVEL_W+BRIGHT_W-1:LEVEL_W];

  // Shared multiplier
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_SEL_LEVEL: begin
        mul_a = A_W'(rom_level);
        mul_b = strip ? B_W'(strip_max_brightness) : B_W'(pwm_max_duty);
      end
      MUL_SEL_RISE: begin
        mul_a = strip ? A_W'(ch_rise) : A_W'(frac);
        mul_b = strip ? B_W'(strip_b) : scale;
      end
      MUL_SEL_FALL: begin
        mul_a = strip ? A_W'(ch_fall) : A_W'(fall_w);
        mul_b = strip ? B_W'(strip_b) : scale;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        MUL_SEL_LEVEL: begin
          scale   <= product[B_W-1:0];
          level_q <= rom_level;
        end
        MUL_SEL_RISE: rise_prod <= product;
        MUL_SEL_FALL: fall_prod <= product;
        default: ;
      endcase
    end
  end

  // Channel values, then per-sector routing
  assign full_val = scale[LEVEL_W+CHAN_W-1:LEVEL_W];
  assign rise_val = strip ? CHAN_W'(div255(rise_prod[15:0]))
                          : rise_prod[FB+LEVEL_W+CHAN_W-1:FB+LEVEL_W];
  assign fall_val = strip ? CHAN_W'(div255(fall_prod[15:0]))
                          : fall_prod[FB+LEVEL_W+CHAN_W-1:FB+LEVEL_W];

  always_comb begin
    unique case (sector)
      3'd0: begin w_red = W_FULL; w_green = W_RISE; w_blue = W_ZERO; end
      3'd1: begin w_red = W_FALL; w_green = W_FULL; w_blue = W_ZERO; end
      3'd2: begin w_red = W_ZERO; w_green = W_FULL; w_blue = W_RISE; end
      3'd3: begin w_red = W_ZERO; w_green = W_FALL; w_blue = W_FULL; end
      3'd4: begin w_red = W_RISE; w_green = W_ZERO; w_blue = W_FULL; end
      default: begin w_red = W_FULL; w_green = W_ZERO; w_blue = W_FALL; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      red_level    <= pick(w_red, rise_val, fall_val, full_val);
      green_level  <= pick(w_green, rise_val, fall_val, full_val);
      blue_level   <= pick(w_blue, rise_val, fall_val, full_val);
      hue_position <= hue_index;
      breath_level <= level_q;
    end
  end

endmodule

>>> src/bclg_controller.sv
// Sequencer of the breathing color LED generator: steps each request through lookup,
// divide and multiply phases and owns the result valid flag. Depends on bclg_pkg.
module bclg_controller
  import bclg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  output logic         m_tvalid,
  input  logic         m_tready,
  output bclg_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   result_valid;
  logic   slot_free;

  assign slot_free = !result_valid || m_tready;
  assign m_tvalid  = result_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    unique case (state)
      ST_IDLE:      state_next = s_tvalid ? ST_LOOKUP : ST_IDLE;
      ST_LOOKUP:    state_next = ST_DIVIDE;
      ST_DIVIDE:    state_next = ST_MUL_LEVEL;
      ST_MUL_LEVEL: state_next = ST_MUL_RISE;
      ST_MUL_RISE:  state_next = ST_MUL_FALL;
      ST_MUL_FALL:  state_next = ST_FINISH;
      ST_FINISH:    state_next = slot_free ? ST_IDLE : ST_FINISH;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_SEL_LEVEL;
    s_tready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.step = s_tvalid;
      end
      ST_LOOKUP:    cmd.lookup   = 1'b1;
      ST_DIVIDE:    cmd.div_step = 1'b1;
      ST_MUL_LEVEL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SEL_LEVEL;
      end
      ST_MUL_RISE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SEL_RISE;
      end
      ST_MUL_FALL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SEL_FALL;
      end
      ST_FINISH:    cmd.load_out = slot_free;
      default: ;
    endcase
  end

  // Hold the result until taken; a new load replaces a taken one in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (m_tready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

>>> src/breathing_color_led_generator_unit.sv
// Top level of the breathing color LED generator: sequencer plus datapath.
// Depends on bclg_pkg, bclg_controller and bclg_datapath.
//
// Usage:
//   Send one request per animation tick on the s_* stream; s_tdata[0] is the tick
//   flag. A set flag advances the hue index (wrapping after STEPS-1) and the breath
//   index (bouncing between 0 and STEPS); a clear flag holds the state. Every
//   request, ticked or not, yields exactly one result on the m_* stream with the
//   red, green and blue levels, the hue index and the sigmoid breath level.
//   Registers must be written through cfg_we / cfg_index / cfg_wdata while idle.
// Sequence:
//   A request is taken only while idle, so the next waits until the last is loaded;
//   each passes a table lookup, one reciprocal multiply for the hue fraction, three
//   passes through the one shared multiplier and the output load, which registers
//   m_tvalid. The block does not enforce that registers are written only while idle.
// Reset and stall:
//   rst (synchronous) clears the animation state and restores the register defaults;
//   no clearing pass is needed, the sigmoid table is constant. A result waits in the
//   output register while m_tready is low and one more request is taken meanwhile;
//   that request then holds in its last phase until the output register frees up.
module breathing_color_led_generator_unit
  import bclg_pkg::*;
#(
  parameter int STEPS         = STEPS_DEFAULT,
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // request stream; s_tdata fields from bit 0: tick[0], zero padding [7:1]
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // result stream; m_tdata fields from bit 0: red_level[12:0], green_level[25:13],
  // blue_level[38:26], hue_position[48:39], breath_level[64:49], zero padding [71:65]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // register write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int PAD_W = OUT_TDATA_W - 3 * CHAN_W - HUE_W - LEVEL_W;

  bclg_cmd_t          cmd;
  logic [CHAN_W-1:0]  red_level;
  logic [CHAN_W-1:0]  green_level;
  logic [CHAN_W-1:0]  blue_level;
  logic [HUE_W-1:0]   hue_position;
  logic [LEVEL_W-1:0] breath_level;

  bclg_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  bclg_datapath #(
    .STEPS         (STEPS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .tick         (s_tdata[0]),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .red_level    (red_level),
    .green_level  (green_level),
    .blue_level   (blue_level),
    .hue_position (hue_position),
    .breath_level (breath_level)
  );

  // Pack result fields, lowest field first
  assign m_tdata = {{PAD_W{1'b0}}, breath_level, hue_position, blue_level, green_level,
                    red_level};

endmodule

>>> src/bclg_checker.sv
// Port-level checker of the breathing color LED generator, bound to the top level.
// Depends on bclg_pkg and breathing_color_led_generator_unit.
module bclg_checker
  import bclg_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // Reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // One request at a time enters the sequencer
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // Full-saturation color: one channel is always off
  a_one_channel_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[12:0] == 13'd0) || (m_tdata[25:13] == 13'd0) ||
                 (m_tdata[38:26] == 13'd0))
    else $error("no channel off in result");

endmodule

bind breathing_color_led_generator_unit bclg_checker u_bclg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> dv/testbench.sv
// Testbench of breathing_color_led_generator_unit: random and directed tick requests,
// cycle-free color predictor and in-order result checking.
// Depends on bclg_pkg and the generator RTL only.
`timescale 1ns / 1ps

module testbench;
  import bclg_pkg::*;

  localparam int STEPS         = STEPS_DEFAULT;
  localparam int FRACTION_BITS = FRACTION_BITS_DEFAULT;

  // m_tdata field offsets, lowest first
  localparam int RED_LSB   = 0;
  localparam int GREEN_LSB = RED_LSB + CHAN_W;
  localparam int BLUE_LSB  = GREEN_LSB + CHAN_W;
  localparam int HUE_LSB   = BLUE_LSB + CHAN_W;
  localparam int LEVEL_LSB = HUE_LSB + HUE_W;

  // Index that maps to no register; a write there must change nothing
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

  localparam int RANDOM_SEGMENTS  = 6;
  localparam int SEGMENT_REQUESTS = 140;
  localparam int HOLD_CYCLES      = 400;
  localparam int IDLE_LIMIT       = 5000;
  localparam int SETTLE_CYCLES    = 30;

  typedef struct {
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [HUE_W-1:0]   hue;
    logic [LEVEL_W-1:0] level;
  } led_color_t;

  // Mirrors the animation state and registers, predicts one color per accepted
  // request and checks results against them in order.
  class led_color_scoreboard;
    bit [LEVEL_W-1:0]  sigmoid_levels [0:STEPS];
    logic              mode;
    logic [DUTY_W-1:0] duty;
    logic [BRIGHT_W-1:0] bright;
    int unsigned       hue;
    int unsigned       breath;
    bit                rising;
    led_color_t        expected_colors [$];
    int                failures;

    function new();
      mode     = OUTPUT_MODE_RESET;
      duty     = PWM_DUTY_RESET;
      bright   = STRIP_BRIGHT_RESET;
      hue      = 0;
      breath   = 0;
      rising   = 1'b1;
      failures = 0;
      build_levels();
    endfunction

    // e^-(r/STEPS) in Q2.30, each Taylor term truncated
    function bit [63:0] exp_series(bit [63:0] r);
      bit [63:0] term;
      bit [63:0] sum;
      term = EXP_ONE;
      sum  = EXP_ONE;
      for (int n = 1; n <= EXP_TERMS; n++) begin
        term = (term * r) / (64'(n) * 64'(STEPS));
        if (n % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      return sum;
    endfunction

    // Sigmoid brightness per breath index, rounded to nearest Q0.16
    function void build_levels();
      bit [63:0] e1;
      bit [63:0] e;
      bit [63:0] mag;
      bit [63:0] whole;
      bit [63:0] d;
      bit [63:0] s;
      longint    offset;
      e1 = exp_series(64'(STEPS));
      for (int k = 0; k <= STEPS; k++) begin
        offset = longint'(2 * STEEPNESS) * k - longint'(STEEPNESS) * STEPS;
        mag    = (offset < 0) ? -offset : offset;
        whole  = mag / STEPS;
        e      = exp_series(mag % STEPS);
        if (whole > 2 * STEEPNESS) begin
          whole = 2 * STEEPNESS;
        end
        for (int i = 0; i < whole; i++) begin
          e = (e * e1) >> EXP_ONE_SHIFT;
        end
        d = EXP_ONE + e;
        if (offset >= 0) begin
          s = ((64'd1 << (EXP_ONE_SHIFT + LEVEL_W)) + d / 2) / d;
        end else begin
          s = ((e << LEVEL_W) + d / 2) / d;
        end
        sigmoid_levels[k] = s[LEVEL_W-1:0];
      end
    endfunction

    function void note_register(logic [CFG_INDEX_W-1:0] index,
                                logic [CFG_DATA_W-1:0] value);
      case (index)
        CFG_OUTPUT_MODE:          mode   = value[0];
        CFG_PWM_MAX_DUTY:         duty   = value[DUTY_W-1:0];
        CFG_STRIP_MAX_BRIGHTNESS: bright = value[BRIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    // Full-saturation hue wheel scaled by the current breath level
    function led_color_t predict_color();
      led_color_t  c;
      bit [63:0]   full;
      bit [63:0]   six;
      bit [63:0]   frac;
      bit [63:0]   lvl;
      bit [63:0]   ch;
      bit [63:0]   peak;
      bit [63:0]   v;
      bit [63:0]   w [3];
      bit [CHAN_W-1:0] out [3];
      int unsigned sector;
      full   = 64'd1 << FRACTION_BITS;
      lvl    = sigmoid_levels[breath];
      six    = 6 * 64'(hue);
      sector = six / STEPS;
      frac   = ((six % STEPS) << FRACTION_BITS) / STEPS;
      case (sector)
        0:       w = '{full, frac, 0};
        1:       w = '{full - frac, full, 0};
        2:       w = '{0, full, frac};
        3:       w = '{0, full - frac, full};
        4:       w = '{frac, 0, full};
        default: w = '{full, 0, full - frac};
      endcase
      for (int j = 0; j < 3; j++) begin
        if (mode == MODE_PWM) begin
          v = (w[j] * lvl * 64'(duty)) >> (FRACTION_BITS + 16);
        end else begin
          ch   = (w[j] * 255) >> FRACTION_BITS;
          peak = (lvl * 64'(bright)) >> 16;
          v    = (ch * peak) / 255;
        end
        out[j] = v[CHAN_W-1:0];
      end
      c.red   = out[0];
      c.green = out[1];
      c.blue  = out[2];
      c.hue   = hue[HUE_W-1:0];
      c.level = lvl[LEVEL_W-1:0];
      return c;
    endfunction

    function void note_request(logic tick);
      if (tick) begin
        hue = (hue + 1 >= STEPS) ? 0 : hue + 1;
        if (rising) begin
          breath++;
          if (breath >= STEPS) begin
            breath = STEPS;
            rising = 1'b0;
          end
        end else if (breath <= 1) begin
          breath = 0;
          rising = 1'b1;
        end else begin
          breath--;
        end
      end
      expected_colors.push_back(predict_color());
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        failures++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data);
      led_color_t want;
      if (expected_colors.size() == 0) begin
        failures++;
        $display("%0t: result with no request pending, expected none, actual %h",
                 $time, data);
        return;
      end
      want = expected_colors.pop_front();
      compare_field("red_level",    want.red,   data[RED_LSB +: CHAN_W]);
      compare_field("green_level",  want.green, data[GREEN_LSB +: CHAN_W]);
      compare_field("blue_level",   want.blue,  data[BLUE_LSB +: CHAN_W]);
      compare_field("hue_position", want.hue,   data[HUE_LSB +: HUE_W]);
      compare_field("breath_level", want.level, data[LEVEL_LSB +: LEVEL_W]);
    endfunction

    function int pending();
      return expected_colors.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  led_color_scoreboard colors = new();

  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int holds_wanted = 0;
  int holds_served = 0;
  int hold_left    = 0;
  int idle_cycles  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  breathing_color_led_generator_unit #(
    .STEPS         (STEPS),
    .FRACTION_BITS (FRACTION_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Result side: drop tready at random, or for a long hold-off when the stimulus asks
  // for one, so the output register fills and the block stalls its request side.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (holds_served != holds_wanted) begin
      holds_served <= holds_wanted;
      hold_left    <= HOLD_CYCLES;
      m_tready     <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Check every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      colors.check_result(m_tdata);
    end
  end

  // Give up once nothing has moved on either stream for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request, idling first in a random share of cycles; hold it until the
  // block takes it. tvalid stays high between back-to-back requests.
  task automatic send_request(input logic tick);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'(tick);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    colors.note_request(tick);
  endtask

  task automatic program_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    colors.note_register(index, value);
  endtask

  // Write every register plus a stray write to the unmapped index, then release
  task automatic apply_settings(input logic [CFG_DATA_W-1:0] mode_raw,
                                input logic [CFG_DATA_W-1:0] duty_raw,
                                input logic [CFG_DATA_W-1:0] bright_raw);
    program_reg(CFG_OUTPUT_MODE, mode_raw);
    program_reg(CFG_PWM_MAX_DUTY, duty_raw);
    program_reg(CFG_STRIP_MAX_BRIGHTNESS, bright_raw);
    program_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Stop offering and wait until every predicted color has come back
  task automatic drain(input int settle);
    s_tvalid <= 1'b0;
    while (colors.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_pace(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  // Register value biased toward its extremes
  function automatic logic [CFG_DATA_W-1:0] pick_value(input int unsigned top);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return CFG_DATA_W'(top);
      default: return CFG_DATA_W'($urandom_range(0, top));
    endcase
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] mode_raw;
    logic [CFG_DATA_W-1:0] bright_raw;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_pace(11, 55);

    // Reset registers: a request without tick first, so the reset state shows
    send_request(1'b0);
    repeat (3) send_request(1'b1);

    // PWM at full duty scale
    drain(4);
    apply_settings(CFG_DATA_W'(MODE_PWM), {DUTY_W{1'b1}}, CFG_DATA_W'(8'hFF));
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);

    // Strip mode set through oversized values: only the low bits must count
    drain(4);
    apply_settings({CFG_DATA_W{1'b1}}, '0, {CFG_DATA_W{1'b1}});
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b1);

    // PWM with zero duty, mode bit cleared under set upper bits
    drain(4);
    apply_settings({{(CFG_DATA_W-1){1'b1}}, MODE_PWM}, '0, 13'h1F00);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);

    // Strip with zero brightness
    drain(4);
    apply_settings(CFG_DATA_W'(MODE_STRIP), {DUTY_W{1'b1}}, '0);
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b0);

    // Random part: mostly ticks so the breath index runs into both clamps and the
    // hue wraps; both modes under each idling pattern.
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      drain(4);
      case (seg / 2)
        0:       set_pace(11, 55);
        1:       set_pace(55, 11);
        default: set_pace(0, 0);
      endcase
      mode_raw   = {CFG_DATA_W'($urandom_range(0, 4095)) << 1} | CFG_DATA_W'(seg % 2);
      bright_raw = pick_value(255) | (CFG_DATA_W'($urandom_range(0, 31)) << BRIGHT_W);
      apply_settings(mode_raw, pick_value({DUTY_W{1'b1}}), bright_raw);
      for (int i = 0; i < SEGMENT_REQUESTS; i++) begin
        // long receiver hold-off while requests keep coming
        if (seg == 4 && i == 10) begin
          holds_wanted <= holds_wanted + 1;
        end
        send_request($urandom_range(0, 9) != 0);
      end
    end

    drain(SETTLE_CYCLES);
    if (colors.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
